[sv/bounded_positional_list_unit_assert.svh]
// Assertion macros used by the positional list top level.
`ifndef BOUNDED_POSITIONAL_LIST_UNIT_ASSERT_SVH
`define BOUNDED_POSITIONAL_LIST_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BPL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list assertion failed");

// Check that cons holds in the cycle after ante.
`define BPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list assertion failed");

`endif

[sv/bpl_pkg.sv]
// Package of commands, status codes, field widths and cell control for the positional list.
package bpl_pkg;

    // input item field widths
    localparam int CMD_W   = 3;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int IN_BITS = CMD_W + POS_W + VAL_W;
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

    // result item field widths
    localparam int RD_W     = 32;
    localparam int CNT_OUT_W = 6;
    localparam int STAT_W   = 2;
    localparam int OUT_BITS = RD_W + CNT_OUT_W + 1 + STAT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_POS = 3'd0,
        CMD_INS_END = 3'd1,
        CMD_DEL_POS = 3'd2,
        CMD_DEL_END = 3'd3,
        CMD_READ    = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_ERR  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // shift controls broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

[sv/bpl_cell.sv]
// One list cell: holds a single entry and shifts with its neighbors.
module bpl_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32,
    parameter int K_W        = 7
) (
    input  logic                  i_clk,
    input  bpl_pkg::t_cell_ctl    i_ctl,
    input  logic [K_W-1:0]        i_k,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_rd
);

    localparam logic [K_W-1:0] MY_IDX = K_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_at;
    logic                  w_after;

    assign w_at    = (i_k == MY_IDX);
    assign w_after = (MY_IDX > i_k);

    // take the new word, shift back from the left, or close the gap from the right
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (w_at) begin
                n_data = i_value;
            end else if (w_after) begin
                n_data = i_left;
            end
        end else if (i_ctl.del) begin
            if (w_at || w_after) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // drive the shared read bus only when addressed
    assign o_data = r_data;
    assign o_rd   = w_at ? r_data : '0;

endmodule

[sv/bounded_positional_list_unit.sv]
// Positional list top level: command decode, cell chain and result register.
// Result: each item's result is registered as the item is accepted and shown in the cycle after.
// Throughput: one item per cycle unless a result waits on m_tready; every cell compares its index with
// the position and shifts in the same cycle, and the result register drains while the next item enters.
// Reset: i_rst_n (synchronous, active low) empties the list and drops a pending result;
// cell contents are left as they are and are never read before being written.
module bounded_positional_list_unit #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // command[2:0], position[8:3], value[40:9], zero fill above
    input  logic [bpl_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // read_value[31:0], count[37:32], empty_res[38], status[40:39], zero fill above
    output logic [bpl_pkg::OUT_W-1:0] m_tdata
);

`include "bounded_positional_list_unit_assert.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > bpl_pkg::POS_W) ? CNT_W : bpl_pkg::POS_W) + 1;
    localparam int EXT_W = (DATA_WIDTH > bpl_pkg::VAL_W) ? DATA_WIDTH : bpl_pkg::VAL_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                       w_accept;
    bpl_pkg::t_cmd              w_cmd;
    logic [bpl_pkg::POS_W-1:0]  w_pos;
    logic [bpl_pkg::VAL_W-1:0]  w_val;
    logic [CMP_W-1:0]           w_pos_c;
    logic [CMP_W-1:0]           w_cnt_c;
    logic [CMP_W-1:0]           w_cnt1_c;
    logic [CMP_W-1:0]           w_k;
    logic [EXT_W-1:0]           w_val_ext;
    logic [DATA_WIDTH-1:0]      w_wr_word;
    logic [DATA_WIDTH-1:0]      w_rd_word;
    logic signed [EXT_W-1:0]    w_rd_ext;
    logic [bpl_pkg::RD_W-1:0]   w_rd_out;
    bpl_pkg::t_status           w_status;
    bpl_pkg::t_cell_ctl         w_ctl;
    bpl_pkg::t_cell_ctl         w_ctl_gated;
    logic                       w_full;

    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_m_valid;
    logic [bpl_pkg::RD_W-1:0]   r_res_rd;
    logic [bpl_pkg::CNT_OUT_W-1:0] r_res_cnt;
    logic                       r_res_empty;
    bpl_pkg::t_status           r_res_stat;

    logic [DATA_WIDTH-1:0]      w_cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0]      w_cell_rd   [CAPACITY];

    // unpack the input item
    assign w_cmd   = bpl_pkg::t_cmd'(s_tdata[bpl_pkg::CMD_W-1:0]);
    assign w_pos   = s_tdata[bpl_pkg::CMD_W +: bpl_pkg::POS_W];
    assign w_val   = s_tdata[bpl_pkg::CMD_W + bpl_pkg::POS_W +: bpl_pkg::VAL_W];

    assign s_tready = !r_m_valid || m_tready;
    assign w_accept = s_tvalid && s_tready;

    assign w_pos_c   = CMP_W'(w_pos);
    assign w_cnt_c   = CMP_W'(r_count);
    assign w_cnt1_c  = w_cnt_c + CMP_W'(1);
    assign w_full    = (r_count == CAP_CNT);
    assign w_val_ext = EXT_W'(w_val);
    assign w_wr_word = w_val_ext[DATA_WIDTH-1:0];

    // sign-extend the addressed entry into the read field
    assign w_rd_ext = EXT_W'(signed'(w_rd_word));
    assign w_rd_out = w_rd_ext[bpl_pkg::RD_W-1:0];

    // decode the command into shift controls, target index and status
    always_comb begin
        w_ctl    = '0;
        w_k      = w_pos_c - CMP_W'(1);
        w_status = bpl_pkg::ST_ERR;
        n_count  = r_count;
        unique case (w_cmd)
            bpl_pkg::CMD_INS_POS: begin
                if (w_pos_c == '0 || w_pos_c > w_cnt1_c) begin
                    w_status = bpl_pkg::ST_ERR;
                end else if (w_full) begin
                    w_status = bpl_pkg::ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    w_status  = bpl_pkg::ST_DONE;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            bpl_pkg::CMD_INS_END: begin
                w_k = w_cnt_c;
                if (w_full) begin
                    w_status = bpl_pkg::ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    w_status  = bpl_pkg::ST_DONE;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            bpl_pkg::CMD_DEL_POS: begin
                if (w_pos_c == '0 || w_pos_c > w_cnt_c) begin
                    w_status = bpl_pkg::ST_ERR;
                end else begin
                    w_ctl.del = 1'b1;
                    w_status  = bpl_pkg::ST_DONE;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            bpl_pkg::CMD_DEL_END: begin
                w_k = w_cnt_c - CMP_W'(1);
                if (r_count == '0) begin
                    w_status = bpl_pkg::ST_ERR;
                end else begin
                    w_ctl.del = 1'b1;
                    w_status  = bpl_pkg::ST_DONE;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            bpl_pkg::CMD_READ: begin
                if (w_pos_c == '0 || w_pos_c > w_cnt_c) begin
                    w_status = bpl_pkg::ST_ERR;
                end else begin
                    w_status = bpl_pkg::ST_DONE;
                end
            end
            default: begin
                w_status = bpl_pkg::ST_ERR;
            end
        endcase
    end

    // shift only on an accepted item
    always_comb begin
        w_ctl_gated     = w_ctl;
        w_ctl_gated.ins = w_ctl.ins && w_accept;
        w_ctl_gated.del = w_ctl.del && w_accept;
    end

    // chain of cells, each wired to its left and right neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_data[g+1];
        end
        bpl_cell #(
            .INDEX      (g),
            .DATA_WIDTH (DATA_WIDTH),
            .K_W        (CMP_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl_gated),
            .i_k     (w_k),
            .i_value (w_wr_word),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell_data[g]),
            .o_rd    (w_cell_rd[g])
        );
    end

    // combine the read bus: at most one cell drives it
    always_comb begin
        w_rd_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_word = w_rd_word | w_cell_rd[i];
        end
    end

    // advance the entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // hold the result until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (w_cmd == bpl_pkg::CMD_READ) begin
                r_res_rd <= (w_status == bpl_pkg::ST_DONE) ? w_rd_out : '1;
            end else begin
                r_res_rd <= '0;
            end
            r_res_cnt   <= bpl_pkg::CNT_OUT_W'(n_count);
            r_res_empty <= (n_count == '0);
            r_res_stat  <= w_status;
        end
    end

    // pack the result item
    assign m_tvalid = r_m_valid;
    assign m_tdata  = bpl_pkg::OUT_W'({r_res_stat, r_res_empty, r_res_cnt, r_res_rd});

    // list never grows past its capacity
    `BPL_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_CNT)
    // an insert refused as full only happens on a full list
    `BPL_ASSERT_IMPLY(a_full_only_at_cap, i_clk, i_rst_n,
        w_accept && w_status == bpl_pkg::ST_FULL, r_count == CAP_CNT)
    // a completed insert grows the list by one
    `BPL_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n,
        w_accept && w_ctl.ins, r_count == $past(r_count) + CNT_W'(1))
    // a bad read returns all ones
    `BPL_ASSERT_NEXT(a_bad_read, i_clk, i_rst_n,
        w_accept && w_cmd == bpl_pkg::CMD_READ && w_status == bpl_pkg::ST_ERR,
        r_res_rd == '1 && r_m_valid)

endmodule
